// ===== hw/rtl/fhs_pkg.sv =====
// ----------------------------------------------------------------------------
// fhs_pkg
// Shared types, constants and code tables for the FLAC frame header search.
// ----------------------------------------------------------------------------
package fhs_pkg;

   localparam int WindowBytesDefault = 16;
   localparam int SkipWidth          = 20;
   localparam int RspDataWidth       = 104;

   localparam logic [SkipWidth-1:0] SkipMax = 20'hFFFFF;

   localparam logic [7:0] SyncByte = 8'hFF;
   localparam logic [7:0] SyncMask = 8'hFE;
   localparam logic [7:0] SyncCode = 8'hF8;

   localparam logic [3:0] BsZero   = 4'd0;
   localparam logic [3:0] BsExt8   = 4'd6;
   localparam logic [3:0] BsExt16  = 4'd7;
   localparam logic [3:0] SrKhz    = 4'd12;
   localparam logic [3:0] SrHz     = 4'd13;
   localparam logic [3:0] SrTenHz  = 4'd14;
   localparam logic [3:0] SrBad    = 4'd15;

   typedef struct packed {
      logic                 vld;
      logic                 eoi;
      logic                 full;
      logic                 limit_hit;
      logic [SkipWidth-1:0] skip;
   } stage_type;

   typedef struct packed {
      logic        variable_blocking;
      logic [3:0]  channel_count;
      logic [4:0]  sample_bits;
      logic [35:0] frame_or_sample_number;
      logic [16:0] samples_per_block;
      logic [19:0] sample_rate;
   } hdr_type;

   function automatic logic [19:0] rate_tab(input logic [3:0] code);
      logic [19:0] r;
      case (code)
         4'd1:    r = 20'd88200;
         4'd2:    r = 20'd176400;
         4'd3:    r = 20'd192000;
         4'd4:    r = 20'd8000;
         4'd5:    r = 20'd16000;
         4'd6:    r = 20'd22050;
         4'd7:    r = 20'd24000;
         4'd8:    r = 20'd32000;
         4'd9:    r = 20'd44100;
         4'd10:   r = 20'd48000;
         4'd11:   r = 20'd96000;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] blk_tab(input logic [3:0] code);
      logic [16:0] b;
      case (code)
         4'd1:    b = 17'd192;
         4'd2:    b = 17'd576;
         4'd3:    b = 17'd1152;
         4'd4:    b = 17'd2304;
         4'd5:    b = 17'd4608;
         4'd8:    b = 17'd256;
         4'd9:    b = 17'd512;
         4'd10:   b = 17'd1024;
         4'd11:   b = 17'd2048;
         4'd12:   b = 17'd4096;
         4'd13:   b = 17'd8192;
         4'd14:   b = 17'd16384;
         4'd15:   b = 17'd32768;
         default: b = 17'd0;
      endcase
      return b;
   endfunction

   function automatic logic [4:0] depth_tab(input logic [2:0] code);
      logic [4:0] d;
      case (code)
         3'd1:    d = 5'd8;
         3'd2:    d = 5'd12;
         3'd4:    d = 5'd16;
         3'd5:    d = 5'd20;
         3'd6:    d = 5'd24;
         default: d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== hw/rtl/flac_frame_header_sync.sv =====
// ----------------------------------------------------------------------------
// flac_frame_header_sync
// Searches a byte stream for a FLAC frame header and reports the decoded
// fields, or a failure, once per search.
//
//   Channel  Direction  Payload
//   req_     in         tdata: data_byte; tuser: start_search; tlast: end_of_input
//   rsp_     out        tuser: found; tdata: decoded fields and bytes_skipped
//   csr_     in         wr_data: skip_limit
//
// One byte is accepted per cycle unless stalled. An accepted byte enters
// the window and stage registers; its result, if any, then moves from the
// stage register to the output register. The only stall comes from the
// output register: while a result waits there and the stage holds one,
// req_tready is low. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module flac_frame_header_sync #(
   parameter int WINDOW_BYTES = fhs_pkg::WindowBytesDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // data_byte
   input  logic                             req_tuser,   // start_search
   input  logic                             req_tlast,   // end_of_input
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // variable_blocking, channel_count, sample_bits, frame_or_sample_number,
   // samples_per_block, sample_rate, bytes_skipped, one zero pad bit
   output logic [fhs_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic                             rsp_tuser,   // found
   input  logic                             csr_wr_en,
   input  logic [fhs_pkg::SkipWidth-1:0]    csr_wr_data
);

   logic [fhs_pkg::SkipWidth-1:0]    skip_limit_ff;
   logic                             done_ff, done_in;
   logic                             rsp_valid_ff;
   logic                             rsp_found_ff;
   logic [fhs_pkg::RspDataWidth-1:0] rsp_data_ff;
   logic [7:0]                       window [WINDOW_BYTES];
   fhs_pkg::stage_type               stage;
   fhs_pkg::hdr_type                 hdr;
   logic                             hdr_ok;
   logic                             s1_emit, s1_found, s1_fire;
   logic                             out_free, advance, accept, drop;

   fhs_window #(.WINDOW_BYTES(WINDOW_BYTES)) u_window (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .drop         (drop),
      .advance      (advance),
      .data_byte    (req_tdata),
      .start_search (req_tuser),
      .end_of_input (req_tlast),
      .skip_limit   (skip_limit_ff),
      .window       (window),
      .stage        (stage)
   );

   fhs_parse #(.WINDOW_BYTES(WINDOW_BYTES)) u_parse (
      .window (window),
      .hdr_ok (hdr_ok),
      .hdr    (hdr)
   );

   always_comb begin
      s1_found   = stage.full && !stage.limit_hit && hdr_ok;
      s1_emit    = stage.vld && (stage.full ?
                   (stage.limit_hit || hdr_ok || stage.eoi) : stage.eoi);
      out_free   = !rsp_valid_ff || rsp_tready;
      advance    = !s1_emit || out_free;
      s1_fire    = s1_emit && out_free;
      req_tready = !stage.vld || advance;
      accept     = req_tvalid && req_tready;
      drop       = !req_tuser && (done_ff || s1_fire);
      done_in    = (accept && req_tuser) ? 1'b0 : (done_ff || s1_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_limit_ff <= '0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            skip_limit_ff <= csr_wr_data;
         end
         done_ff <= done_in;
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_found_ff <= s1_found;
         if (s1_found) begin
            rsp_data_ff <= {1'b0, stage.skip, hdr.sample_rate, hdr.samples_per_block,
                            hdr.frame_or_sample_number, hdr.sample_bits,
                            hdr.channel_count, hdr.variable_blocking};
         end else begin
            rsp_data_ff <= {1'b0, stage.skip, 83'd0};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_done_after_result: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !(accept && req_tuser) |=> done_ff)
      else $error("search not closed after a result");

   a_failure_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[82:0] == 83'd0)
      else $error("failure result carries nonzero header fields");

   a_found_channels: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[4:1] != 4'd0 && rsp_tdata[4:1] <= 4'd8)
      else $error("found result with channel count out of range");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff && stage.vld && s1_emit)
      else $error("input stalled without a pending result");

endmodule

// ===== hw/rtl/fhs_window.sv =====
// ----------------------------------------------------------------------------
// fhs_window
// Sliding byte window, fill and skip counters, and the stage register that
// carries the per-byte flags to the header check.
// ----------------------------------------------------------------------------
module fhs_window #(
   parameter int WINDOW_BYTES = fhs_pkg::WindowBytesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          drop,
   input  logic                          advance,
   input  logic [7:0]                    data_byte,
   input  logic                          start_search,
   input  logic                          end_of_input,
   input  logic [fhs_pkg::SkipWidth-1:0] skip_limit,
   output logic [7:0]                    window [WINDOW_BYTES],
   output fhs_pkg::stage_type            stage
);

   localparam int FillWidth = $clog2(WINDOW_BYTES + 1);
   localparam logic [FillWidth-1:0] FillFull = FillWidth'(WINDOW_BYTES);

   logic [7:0]                    window_ff [WINDOW_BYTES];
   logic [FillWidth-1:0]          fill_ff, fill_in, fill_base;
   logic [fhs_pkg::SkipWidth-1:0] skip_ff, skip_in, skip_base;
   fhs_pkg::stage_type            stage_ff, stage_in;
   logic                          shift_full;

   always_comb begin
      fill_base  = start_search ? '0 : fill_ff;
      skip_base  = start_search ? '0 : skip_ff;
      shift_full = (fill_base == FillFull);
      fill_in    = fill_ff;
      skip_in    = skip_ff;
      stage_in   = stage_ff;
      if (advance) begin
         stage_in.vld = 1'b0;
      end
      if (accept) begin
         if (drop) begin
            stage_in.vld = 1'b0;
         end else begin
            fill_in = shift_full ? fill_base : fill_base + FillWidth'(1);
            skip_in = (shift_full && skip_base != fhs_pkg::SkipMax) ?
                      skip_base + fhs_pkg::SkipWidth'(1) : skip_base;
            stage_in.vld       = 1'b1;
            stage_in.eoi       = end_of_input;
            stage_in.full      = (fill_in == FillFull);
            stage_in.limit_hit = (skip_limit != '0) && (skip_in >= skip_limit);
            stage_in.skip      = skip_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         skip_ff  <= '0;
         stage_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         skip_ff  <= skip_in;
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !drop) begin
         for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[WINDOW_BYTES-1] <= data_byte;
      end
   end

   assign window = window_ff;
   assign stage  = stage_ff;

endmodule

// ===== hw/rtl/fhs_parse.sv =====
// ----------------------------------------------------------------------------
// fhs_parse
// Checks the window, oldest byte first, as a frame header and decodes its
// fields, including the coded number and the extension bytes.
// ----------------------------------------------------------------------------
module fhs_parse #(
   parameter int WINDOW_BYTES = fhs_pkg::WindowBytesDefault
) (
   input  logic [7:0]       window [WINDOW_BYTES],
   output logic             hdr_ok,
   output fhs_pkg::hdr_type hdr
);

   logic [3:0]  bsc, src, chc, lead;
   logic [2:0]  bdc, ncont;
   logic        sync_ok, codes_ok, lead_ok, cont_ok;
   logic [7:0]  b4, r0, r1;
   logic [7:0]  ext [4];
   logic [35:0] num;
   logic [16:0] blk;
   logic [19:0] rate;

   always_comb begin
      b4  = window[4];
      bsc = window[2][7:4];
      src = window[2][3:0];
      chc = window[3][7:4];
      bdc = window[3][3:1];

      sync_ok  = (window[0] == fhs_pkg::SyncByte) &&
                 ((window[1] & fhs_pkg::SyncMask) == fhs_pkg::SyncCode);
      codes_ok = (bsc != fhs_pkg::BsZero) && (src != fhs_pkg::SrBad) &&
                 (chc inside {[4'd0:4'd10]}) && !(bdc inside {3'd3, 3'd7}) &&
                 !window[3][0];

      if (!b4[7])      lead = 4'd0;
      else if (!b4[6]) lead = 4'd1;
      else if (!b4[5]) lead = 4'd2;
      else if (!b4[4]) lead = 4'd3;
      else if (!b4[3]) lead = 4'd4;
      else if (!b4[2]) lead = 4'd5;
      else if (!b4[1]) lead = 4'd6;
      else if (!b4[0]) lead = 4'd7;
      else             lead = 4'd8;
      lead_ok = (lead != 4'd1) && (lead != 4'd8);

      cont_ok = 1'b1;
      for (int k = 1; k < 7; k++) begin
         if ((4'(k) < lead) && (window[4+k][7:6] != 2'b10)) begin
            cont_ok = 1'b0;
         end
      end

      case (lead)
         4'd2:    num = 36'({b4[4:0], window[5][5:0]});
         4'd3:    num = 36'({b4[3:0], window[5][5:0], window[6][5:0]});
         4'd4:    num = 36'({b4[2:0], window[5][5:0], window[6][5:0],
                             window[7][5:0]});
         4'd5:    num = 36'({b4[1:0], window[5][5:0], window[6][5:0],
                             window[7][5:0], window[8][5:0]});
         4'd6:    num = 36'({b4[0], window[5][5:0], window[6][5:0],
                             window[7][5:0], window[8][5:0], window[9][5:0]});
         4'd7:    num = {window[5][5:0], window[6][5:0], window[7][5:0],
                         window[8][5:0], window[9][5:0], window[10][5:0]};
         default: num = 36'(b4);
      endcase

      ncont = (lead == 4'd0) ? 3'd0 : 3'(lead - 4'd1);
      for (int j = 0; j < 4; j++) begin
         case (ncont)
            3'd0:    ext[j] = window[5+j];
            3'd1:    ext[j] = window[6+j];
            3'd2:    ext[j] = window[7+j];
            3'd3:    ext[j] = window[8+j];
            3'd4:    ext[j] = window[9+j];
            3'd5:    ext[j] = window[10+j];
            3'd6:    ext[j] = window[11+j];
            default: ext[j] = '0;
         endcase
      end

      case (bsc)
         fhs_pkg::BsExt8: begin
            blk = 17'(ext[0]) + 17'd1;
            r0  = ext[1];
            r1  = ext[2];
         end
         fhs_pkg::BsExt16: begin
            blk = 17'({ext[0], ext[1]}) + 17'd1;
            r0  = ext[2];
            r1  = ext[3];
         end
         default: begin
            blk = fhs_pkg::blk_tab(bsc);
            r0  = ext[0];
            r1  = ext[1];
         end
      endcase

      case (src)
         fhs_pkg::SrKhz:   rate = 20'(r0) * 20'd1000;
         fhs_pkg::SrHz:    rate = 20'({r0, r1});
         fhs_pkg::SrTenHz: rate = 20'({r0, r1}) * 20'd10;
         fhs_pkg::SrBad:   rate = 20'd0;
         default:          rate = fhs_pkg::rate_tab(src);
      endcase

      hdr_ok                     = sync_ok && codes_ok && lead_ok && cont_ok;
      hdr.variable_blocking      = window[1][0];
      hdr.channel_count          = (chc < 4'd8) ? chc + 4'd1 : 4'd2;
      hdr.sample_bits            = fhs_pkg::depth_tab(bdc);
      hdr.frame_or_sample_number = num;
      hdr.samples_per_block      = blk;
      hdr.sample_rate            = rate;
   end

endmodule

// ===== sim/tb_flac_frame_header_sync.sv =====
// ----------------------------------------------------------------------------
// tb_flac_frame_header_sync
// Self-checking testbench for the FLAC frame header search. Byte requests,
// mostly well-formed frame headers with noise, broken codes and early
// end marks, are streamed in under random idling. A byte-level predictor
// tracks the byte window and skip count. Every response is compared field by
// field against the oldest predicted header or failure.
// ----------------------------------------------------------------------------
module tb_flac_frame_header_sync;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          WinBytes       = 16;
   localparam int          SearchBytes    = 120;
   localparam int unsigned CycleLimit     = 500000;
   localparam logic [3:0]  BsShort        = 4'd1;
   localparam logic [3:0]  BsPow2First    = 4'd8;
   localparam logic [3:0]  ChanIndepLast  = 4'd7;
   localparam logic [3:0]  ChanStereoLast = 4'd10;
   localparam logic [2:0]  DepthReserved3 = 3'd3;
   localparam logic [2:0]  DepthReserved7 = 3'd7;

   typedef struct packed {
      logic        found;
      logic        variable_blocking;
      logic [3:0]  channel_count;
      logic [4:0]  sample_bits;
      logic [35:0] frame_or_sample_number;
      logic [16:0] samples_per_block;
      logic [19:0] sample_rate;
      logic [19:0] bytes_skipped;
   } header_result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       last;
   } stream_byte_type;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata   = '0;
   logic                             req_tuser   = 1'b0;
   logic                             req_tlast   = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   logic [fhs_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_wr_en   = 1'b0;
   logic [fhs_pkg::SkipWidth-1:0]    csr_wr_data = '0;

   logic [19:0] rate_hz [16] = '{20'd0, 20'd88200, 20'd176400, 20'd192000,
                                 20'd8000, 20'd16000, 20'd22050, 20'd24000,
                                 20'd32000, 20'd44100, 20'd48000, 20'd96000,
                                 20'd0, 20'd0, 20'd0, 20'd0};
   logic [4:0]  depth_bits [8] = '{5'd0, 5'd8, 5'd12, 5'd0, 5'd16, 5'd20, 5'd24, 5'd0};

   logic [7:0]                    byte_win [WinBytes];
   int unsigned                   win_fill;
   logic [fhs_pkg::SkipWidth-1:0] skip_cnt         = '0;
   bit                            search_over;
   logic [fhs_pkg::SkipWidth-1:0] skip_limit_model = '0;

   stream_byte_type   byte_queue[$];
   header_result_type expected_headers[$];
   stream_byte_type   next_byte;
   int unsigned       queued_bytes;
   int unsigned       send_gap;
   int unsigned       stall_left;
   int unsigned       hold_left;
   bit                hold_pending;
   bit                hold_done;
   bit                steady;
   int unsigned       mismatches;
   int unsigned       cycle_count;

   flac_frame_header_sync dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic header_result_type decode_window();
      header_result_type r;
      logic [3:0]        bsc, src, chc;
      logic [2:0]        bdc;
      logic [63:0]       num;
      logic [31:0]       blk, rate;
      int                lead, pos, k;
      bit                ok;
      r   = '0;
      bsc = byte_win[2][7:4];
      src = byte_win[2][3:0];
      chc = byte_win[3][7:4];
      bdc = byte_win[3][3:1];
      ok  = (byte_win[0] == fhs_pkg::SyncByte) &&
            ((byte_win[1] & fhs_pkg::SyncMask) == fhs_pkg::SyncCode) &&
            (bsc != fhs_pkg::BsZero) && (src != fhs_pkg::SrBad) &&
            (chc <= ChanStereoLast) && (bdc != DepthReserved3) &&
            (bdc != DepthReserved7) && !byte_win[3][0];
      lead = 0;
      while (lead < 8 && byte_win[4][7 - lead])
         lead++;
      if (lead == 1 || lead == 8)
         ok = 1'b0;
      num = 64'(byte_win[4] & (8'h7F >> lead));
      pos = 5;
      for (k = 1; ok && k < lead; k++) begin
         if (byte_win[pos][7:6] != 2'b10)
            ok = 1'b0;
         num = (num << 6) | 64'(byte_win[pos][5:0]);
         pos++;
      end
      if (ok) begin
         if (bsc == fhs_pkg::BsExt8) begin
            blk = 32'(byte_win[pos]) + 1;
            pos += 1;
         end else if (bsc == fhs_pkg::BsExt16) begin
            blk = 32'({byte_win[pos], byte_win[pos + 1]}) + 1;
            pos += 2;
         end else if (bsc == BsShort) begin
            blk = 192;
         end else if (bsc < fhs_pkg::BsExt8) begin
            blk = 576 << (bsc - BsShort - 1);
         end else begin
            blk = 256 << (bsc - BsPow2First);
         end
         if (src < fhs_pkg::SrKhz)
            rate = 32'(rate_hz[src]);
         else if (src == fhs_pkg::SrKhz)
            rate = 32'(byte_win[pos]) * 1000;
         else if (src == fhs_pkg::SrHz)
            rate = 32'({byte_win[pos], byte_win[pos + 1]});
         else
            rate = 32'({byte_win[pos], byte_win[pos + 1]}) * 10;
         r.found                  = 1'b1;
         r.variable_blocking      = byte_win[1][0];
         r.channel_count          = (chc <= ChanIndepLast) ? 4'(chc + 1) : 4'd2;
         r.sample_bits            = depth_bits[bdc];
         r.frame_or_sample_number = num[35:0];
         r.samples_per_block      = blk[16:0];
         r.sample_rate            = rate[19:0];
      end
      return r;
   endfunction

   task automatic absorb_byte(input logic [7:0] b, input logic start, input logic eoi);
      header_result_type r;
      bit                limit_hit;
      int                i;
      r         = '0;
      limit_hit = 1'b0;
      if (start) begin
         for (i = 0; i < WinBytes; i++)
            byte_win[i] = '0;
         win_fill    = 0;
         skip_cnt    = '0;
         search_over = 1'b0;
      end
      if (!search_over) begin
         if (win_fill < WinBytes) begin
            byte_win[win_fill] = b;
            win_fill++;
         end else begin
            for (i = 0; i < WinBytes - 1; i++)
               byte_win[i] = byte_win[i + 1];
            byte_win[WinBytes - 1] = b;
            if (skip_cnt != fhs_pkg::SkipMax)
               skip_cnt++;
         end
         if (win_fill == WinBytes) begin
            limit_hit = (skip_limit_model != 0) && (skip_cnt >= skip_limit_model);
            if (!limit_hit)
               r = decode_window();
         end
         if (r.found || eoi || limit_hit) begin
            r.bytes_skipped = skip_cnt;
            search_over     = 1'b1;
            expected_headers.push_back(r);
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_header();
      header_result_type want;
      if (expected_headers.size() == 0) begin
         $error("response with no header or failure pending");
         mismatches++;
      end else begin
         want = expected_headers.pop_front();
         compare_field("found", want.found, rsp_tuser);
         compare_field("variable_blocking", want.variable_blocking, rsp_tdata[0]);
         compare_field("channel_count", want.channel_count, rsp_tdata[4:1]);
         compare_field("sample_bits", want.sample_bits, rsp_tdata[9:5]);
         compare_field("frame_or_sample_number", want.frame_or_sample_number,
                       rsp_tdata[45:10]);
         compare_field("samples_per_block", want.samples_per_block, rsp_tdata[62:46]);
         compare_field("sample_rate", want.sample_rate, rsp_tdata[82:63]);
         compare_field("bytes_skipped", want.bytes_skipped, rsp_tdata[102:83]);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            check_header();
         if (req_tvalid && req_tready)
            absorb_byte(req_tdata, req_tuser, req_tlast);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (byte_queue.size() != 0) begin
            next_byte  = byte_queue.pop_front();
            req_tdata  <= next_byte.data;
            req_tuser  <= next_byte.start;
            req_tlast  <= next_byte.last;
            req_tvalid <= 1'b1;
            send_gap   <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_pending && !hold_done) begin
         hold_left  <= 400;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (steady || $urandom_range(0, 99) < 75) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("** flac_frame_header_sync: FAILED **");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] d, input logic s, input logic l);
      stream_byte_type it;
      it.data  = d;
      it.start = s;
      it.last  = l;
      byte_queue.push_back(it);
      queued_bytes++;
   endtask

   task automatic push_word(input logic [127:0] w);
      int i;
      for (i = 0; i < WinBytes; i++)
         push_byte(w[127 - 8 * i -: 8], i == 0, 1'b0);
   endtask

   task automatic queue_search();
      logic [7:0]  seq[$];
      logic [7:0]  first;
      logic [3:0]  bsc, src, chc;
      logic [2:0]  bdc;
      logic        resv;
      int unsigned mode, lead, pre, hdr_at, idx;
      bit          with_start, with_eoi;
      mode       = $urandom_range(0, 19);
      with_start = ($urandom_range(0, 19) != 0);
      with_eoi   = ($urandom_range(0, 4) == 0);
      if (mode == 0) begin
         pre = $urandom_range(1, 15);
         for (idx = 0; idx < pre; idx++)
            seq.push_back(8'($urandom));
         with_eoi = 1'b1;
      end else begin
         if (mode <= 2) begin
            bsc  = 4'($urandom);
            src  = 4'($urandom);
            chc  = 4'($urandom);
            bdc  = 3'($urandom);
            resv = 1'($urandom);
            lead = $urandom_range(0, 8);
         end else begin
            bsc = 4'($urandom_range(1, 15));
            src = 4'($urandom_range(0, 14));
            chc = 4'($urandom_range(0, 10));
            do
               bdc = 3'($urandom);
            while (bdc == DepthReserved3 || bdc == DepthReserved7);
            resv = 1'b0;
            lead = $urandom_range(0, 6);
            if (lead != 0)
               lead++;
         end
         pre = $urandom_range(0, 99);
         pre = (pre < 50) ? 0 : (pre < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         for (idx = 0; idx < pre; idx++)
            seq.push_back(($urandom_range(0, 3) == 0) ? fhs_pkg::SyncByte : 8'($urandom));
         hdr_at = seq.size();
         seq.push_back(fhs_pkg::SyncByte);
         seq.push_back(fhs_pkg::SyncCode | 8'($urandom_range(0, 1)));
         seq.push_back({bsc, src});
         seq.push_back({chc, bdc, resv});
         if (lead == 0)
            first = {1'b0, 7'($urandom)};
         else if (lead == 8)
            first = 8'hFF;
         else
            first = (8'hFF << (8 - lead)) | (8'($urandom) & (8'h7F >> lead));
         seq.push_back(first);
         for (idx = 1; idx < lead && idx < 7; idx++)
            seq.push_back({2'b10, 6'($urandom)});
         if (bsc == fhs_pkg::BsExt8 || bsc == fhs_pkg::BsExt16)
            seq.push_back(8'($urandom));
         if (bsc == fhs_pkg::BsExt16)
            seq.push_back(8'($urandom));
         if (src == fhs_pkg::SrKhz || src == fhs_pkg::SrHz || src == fhs_pkg::SrTenHz)
            seq.push_back(8'($urandom));
         if (src == fhs_pkg::SrHz || src == fhs_pkg::SrTenHz)
            seq.push_back(8'($urandom));
         seq.push_back(8'($urandom));
         if (mode == 3) begin
            idx      = $urandom_range(hdr_at, seq.size() - 1);
            seq[idx] = seq[idx] ^ (8'h01 << $urandom_range(0, 7));
         end
         pre = hdr_at + WinBytes + $urandom_range(0, 3);
         while (seq.size() < pre)
            seq.push_back(8'($urandom));
      end
      for (idx = 0; idx < seq.size(); idx++)
         push_byte(seq[idx], (idx == 0) && with_start, with_eoi && (idx == seq.size() - 1));
   endtask

   task automatic write_skip_limit(input logic [fhs_pkg::SkipWidth-1:0] value);
      @(posedge clock);
      csr_wr_en        <= 1'b1;
      csr_wr_data      <= value;
      skip_limit_model = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (byte_queue.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_headers.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int unsigned                   phase, phase_start;
      logic [fhs_pkg::SkipWidth-1:0] limit;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      push_word(128'hFFF97EAC_FEBFBFBF_BFBFBFFF_FFFFFF00);
      push_word(128'hFFF81000_00000000_00000000_00000000);
      push_byte(8'hA5, 1'b1, 1'b1);
      wait_drained();
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       limit = '0;
            1:       limit = fhs_pkg::SkipMax;
            2:       limit = 20'd1;
            3:       limit = 20'($urandom_range(3, 40));
            default: limit = '0;
         endcase
         write_skip_limit(limit);
         steady       = (phase == 2);
         hold_pending = (phase == 0);
         phase_start  = queued_bytes;
         while (queued_bytes - phase_start < SearchBytes)
            queue_search();
         wait_drained();
      end
      if (mismatches == 0)
         $display("** flac_frame_header_sync: PASSED **");
      else
         $display("** flac_frame_header_sync: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/fhs_pkg.sv
hw/rtl/fhs_window.sv
hw/rtl/fhs_parse.sv
hw/rtl/flac_frame_header_sync.sv
sim/tb_flac_frame_header_sync.sv
